### design/dpsp_pkg.sv
package dpsp_pkg;

   typedef enum logic [3:0] {
      PH_OPEN       = 4'd0,
      PH_NAME_START = 4'd1,
      PH_NAME       = 4'd2,
      PH_TEXT       = 4'd3,
      PH_SIZE_FIRST = 4'd4,
      PH_SIZE_MORE  = 4'd5,
      PH_SIZE_COLON = 4'd6,
      PH_BIN_DATA   = 4'd7,
      PH_BIN_SEMI   = 4'd8,
      PH_DONE       = 4'd9,
      PH_FAILED     = 4'd10
   } phase_type;

   typedef enum logic [3:0] {
      KIND_NONE        = 4'd0,
      KIND_NAME_BYTE   = 4'd1,
      KIND_NAME_SIMPLE = 4'd2,
      KIND_NAME_BINARY = 4'd3,
      KIND_TEXT_BYTE   = 4'd4,
      KIND_BIN_BYTE    = 4'd5,
      KIND_PROP_DONE   = 4'd6,
      KIND_DICT_DONE   = 4'd7,
      KIND_ERROR       = 4'd8
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE           = 4'd0,
      ERR_EOI_OPEN       = 4'd1,
      ERR_NOT_OPEN       = 4'd2,
      ERR_EOI_NAME_START = 4'd3,
      ERR_EMPTY_NAME     = 4'd4,
      ERR_EOI_NAME       = 4'd5,
      ERR_EOI_TEXT       = 4'd6,
      ERR_EOI_SIZE       = 4'd7,
      ERR_BAD_SIZE       = 4'd8,
      ERR_EOI_SIZE_COLON = 4'd9,
      ERR_NOT_SIZE_COLON = 4'd10,
      ERR_EOI_BIN_DATA   = 4'd11,
      ERR_EOI_BIN_SEMI   = 4'd12,
      ERR_NOT_BIN_SEMI   = 4'd13
   } err_type;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // One registered stream item on its way from the input stage to the parser.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       eoi;
   } stage_type;

endpackage

### design/dpsp_in_reg.sv
module dpsp_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_input,
   input  logic                take,
   output dpsp_pkg::stage_type stage
);
   import dpsp_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       eoi_ff;

   // The register frees up in the same cycle the parser takes its transaction.
   assign req_stall = valid_ff && !take;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         data_ff <= req_in_byte;
         eoi_ff  <= req_end_of_input;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;
   assign stage.eoi   = eoi_ff;

endmodule

### design/dpsp_core.sv
module dpsp_core #(
   parameter int SIZE_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  dpsp_pkg::stage_type stage,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_kind,
   output logic [7:0]          rsp_out_byte,
   output logic [3:0]          rsp_error_code
);
   import dpsp_pkg::*;

   localparam int PROD_BITS = SIZE_BITS + 4;

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   err_type              hold_ff, hold_in;
   logic                 valid_ff, valid_in;
   kind_type             kind_ff, kind_in;
   logic [7:0]           byte_ff, byte_in;
   err_type              code_ff, code_in;

   logic                 fail;
   err_type              fail_code;
   logic [PROD_BITS-1:0] prod;
   logic [SIZE_BITS-1:0] left_dec;
   logic [7:0]           c;

   assign take = stage.valid && (!valid_ff || !rsp_stall);
   assign c    = stage.data;

   // Size times ten plus the digit; any carry above the size width saturates.
   assign prod = ({4'b0, left_ff} << 3) + ({4'b0, left_ff} << 1)
               + {{(PROD_BITS-4){1'b0}}, 4'(c - CH_ZERO)};
   assign left_dec = (left_ff != '0) ? left_ff - 1'b1 : '0;

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      hold_in   = hold_ff;
      kind_in   = KIND_NONE;
      byte_in   = 8'h00;
      code_in   = ERR_NONE;
      fail      = 1'b0;
      fail_code = ERR_NONE;
      case (phase_ff)
         PH_OPEN: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_OPEN;
            end else if (c != CH_LBRACE) begin
               fail = 1'b1; fail_code = ERR_NOT_OPEN;
            end else begin
               phase_in = PH_NAME_START;
            end
         end
         PH_NAME_START: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_NAME_START;
            end else if (c == CH_RBRACE) begin
               phase_in = PH_DONE;
               kind_in  = KIND_DICT_DONE;
            end else if (c inside {CH_COLON, CH_LPAREN}) begin
               fail = 1'b1; fail_code = ERR_EMPTY_NAME;
            end else begin
               phase_in = PH_NAME;
               kind_in  = KIND_NAME_BYTE;
               byte_in  = c;
            end
         end
         PH_NAME: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_NAME;
            end else if (c == CH_COLON) begin
               phase_in = PH_TEXT;
               kind_in  = KIND_NAME_SIMPLE;
            end else if (c == CH_LPAREN) begin
               phase_in = PH_SIZE_FIRST;
               left_in  = '0;
               kind_in  = KIND_NAME_BINARY;
            end else begin
               kind_in = KIND_NAME_BYTE;
               byte_in = c;
            end
         end
         PH_TEXT: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_TEXT;
            end else if (c == CH_SEMI) begin
               phase_in = PH_NAME_START;
               kind_in  = KIND_PROP_DONE;
            end else begin
               kind_in = KIND_TEXT_BYTE;
               byte_in = c;
            end
         end
         PH_SIZE_FIRST, PH_SIZE_MORE: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_SIZE;
            end else if (c == CH_RPAREN && phase_ff == PH_SIZE_MORE) begin
               phase_in = PH_SIZE_COLON;
            end else if (!(c inside {[CH_ZERO:CH_NINE]})) begin
               fail = 1'b1; fail_code = ERR_BAD_SIZE;
            end else begin
               phase_in = PH_SIZE_MORE;
               if (prod[PROD_BITS-1:SIZE_BITS] != 4'h0) begin
                  left_in = '1;
               end else begin
                  left_in = prod[SIZE_BITS-1:0];
               end
            end
         end
         PH_SIZE_COLON: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_SIZE_COLON;
            end else if (c != CH_COLON) begin
               fail = 1'b1; fail_code = ERR_NOT_SIZE_COLON;
            end else begin
               phase_in = (left_ff == '0) ? PH_BIN_SEMI : PH_BIN_DATA;
            end
         end
         PH_BIN_DATA: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_BIN_DATA;
            end else begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_BIN_SEMI;
               end
               kind_in = KIND_BIN_BYTE;
               byte_in = c;
            end
         end
         PH_BIN_SEMI: begin
            if (stage.eoi) begin
               fail = 1'b1; fail_code = ERR_EOI_BIN_SEMI;
            end else if (c != CH_SEMI) begin
               fail = 1'b1; fail_code = ERR_NOT_BIN_SEMI;
            end else begin
               phase_in = PH_NAME_START;
               kind_in  = KIND_PROP_DONE;
            end
         end
         PH_DONE: begin
            kind_in = KIND_NONE;
         end
         default: begin
            // Errors are sticky: repeat the held code for every transaction.
            phase_in = PH_FAILED;
            kind_in  = KIND_ERROR;
            code_in  = hold_ff;
         end
      endcase
      if (fail) begin
         phase_in = PH_FAILED;
         hold_in  = fail_code;
         kind_in  = KIND_ERROR;
         code_in  = fail_code;
         byte_in  = 8'h00;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         left_ff  <= '0;
         hold_ff  <= ERR_NONE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            hold_ff  <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         code_ff <= code_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_error_code = code_ff;

endmodule

### design/dict_property_stream_parser_top.sv
// A result passes the input register, which loads at the accepting edge, and the result
// register, which the parse logic loads when the parser takes the transaction; a stall on
// the result side can delay that take.
// Throughput: one byte or end-of-input mark per cycle while the result side does not stall,
// with the parse phase and the size counter updated together for each transaction.
// Reset is synchronous and active high; it returns the parser to waiting for
// the opening brace, clears the size count and the held error, and empties both stages.
module dict_property_stream_parser_top #(
   parameter int SIZE_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_error_code
);
   import dpsp_pkg::*;

   stage_type stage;
   logic      take;

   dpsp_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .take             (take),
      .stage            (stage)
   );

   dpsp_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .stage          (stage),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code)
   );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import dpsp_pkg::*;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          RANDOM_ITEMS  = 800;
   localparam logic [63:0] SIZE_CEILING  = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      err_type    code;
   } parse_token_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [3:0] rsp_error_code;

   // Shadow copy of the parser state, advanced once per accepted transaction.
   phase_type     pred_phase = PH_OPEN;
   logic [63:0]   pred_remaining = '0;
   err_type       pred_fault = ERR_NONE;

   parse_token_type pending_tokens[$];
   int            mismatch_count = 0;
   int            sent_count = 0;
   int            cycle_count = 0;
   bit            req_burst = 1'b0;
   bit            rsp_burst = 1'b0;
   int            rsp_hold_left = 0;
   int            rsp_gap;

   dict_property_stream_parser_top #(
      .SIZE_BITS(64)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_code  (rsp_error_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic parse_token_type make_token(kind_type k, logic [7:0] d, err_type c);
      parse_token_type t;
      t.kind = k;
      t.data = d;
      t.code = c;
      return t;
   endfunction

   function automatic parse_token_type parse_fault(err_type c);
      pred_phase = PH_FAILED;
      pred_fault = c;
      return make_token(KIND_ERROR, 8'h00, c);
   endfunction

   function automatic parse_token_type predict_parse(logic [7:0] b, logic eoi);
      parse_token_type t;
      logic [63:0]  digit;
      t = make_token(KIND_NONE, 8'h00, ERR_NONE);
      case (pred_phase)
         PH_OPEN: begin
            if (eoi) t = parse_fault(ERR_EOI_OPEN);
            else if (b != CH_LBRACE) t = parse_fault(ERR_NOT_OPEN);
            else pred_phase = PH_NAME_START;
         end
         PH_NAME_START: begin
            if (eoi) begin
               t = parse_fault(ERR_EOI_NAME_START);
            end else if (b == CH_RBRACE) begin
               pred_phase = PH_DONE;
               t = make_token(KIND_DICT_DONE, 8'h00, ERR_NONE);
            end else if (b == CH_COLON || b == CH_LPAREN) begin
               t = parse_fault(ERR_EMPTY_NAME);
            end else begin
               pred_phase = PH_NAME;
               t = make_token(KIND_NAME_BYTE, b, ERR_NONE);
            end
         end
         PH_NAME: begin
            if (eoi) begin
               t = parse_fault(ERR_EOI_NAME);
            end else if (b == CH_COLON) begin
               pred_phase = PH_TEXT;
               t = make_token(KIND_NAME_SIMPLE, 8'h00, ERR_NONE);
            end else if (b == CH_LPAREN) begin
               pred_phase = PH_SIZE_FIRST;
               pred_remaining = '0;
               t = make_token(KIND_NAME_BINARY, 8'h00, ERR_NONE);
            end else begin
               t = make_token(KIND_NAME_BYTE, b, ERR_NONE);
            end
         end
         PH_TEXT: begin
            if (eoi) begin
               t = parse_fault(ERR_EOI_TEXT);
            end else if (b == CH_SEMI) begin
               pred_phase = PH_NAME_START;
               t = make_token(KIND_PROP_DONE, 8'h00, ERR_NONE);
            end else begin
               t = make_token(KIND_TEXT_BYTE, b, ERR_NONE);
            end
         end
         PH_SIZE_FIRST, PH_SIZE_MORE: begin
            if (eoi) begin
               t = parse_fault(ERR_EOI_SIZE);
            end else if (b == CH_RPAREN && pred_phase == PH_SIZE_MORE) begin
               pred_phase = PH_SIZE_COLON;
            end else if (b < CH_ZERO || b > CH_NINE) begin
               t = parse_fault(ERR_BAD_SIZE);
            end else begin
               // The decimal size clamps at the all-ones value instead of wrapping.
               digit = 64'(b - CH_ZERO);
               if (pred_remaining > (SIZE_CEILING - digit) / 64'd10)
                  pred_remaining = SIZE_CEILING;
               else
                  pred_remaining = pred_remaining * 64'd10 + digit;
               pred_phase = PH_SIZE_MORE;
            end
         end
         PH_SIZE_COLON: begin
            if (eoi) t = parse_fault(ERR_EOI_SIZE_COLON);
            else if (b != CH_COLON) t = parse_fault(ERR_NOT_SIZE_COLON);
            else pred_phase = (pred_remaining == 0) ? PH_BIN_SEMI : PH_BIN_DATA;
         end
         PH_BIN_DATA: begin
            if (eoi) begin
               t = parse_fault(ERR_EOI_BIN_DATA);
            end else begin
               if (pred_remaining != 0) pred_remaining = pred_remaining - 64'd1;
               if (pred_remaining == 0) pred_phase = PH_BIN_SEMI;
               t = make_token(KIND_BIN_BYTE, b, ERR_NONE);
            end
         end
         PH_BIN_SEMI: begin
            if (eoi) begin
               t = parse_fault(ERR_EOI_BIN_SEMI);
            end else if (b != CH_SEMI) begin
               t = parse_fault(ERR_NOT_BIN_SEMI);
            end else begin
               pred_phase = PH_NAME_START;
               t = make_token(KIND_PROP_DONE, 8'h00, ERR_NONE);
            end
         end
         PH_DONE: begin
            t = make_token(KIND_NONE, 8'h00, ERR_NONE);
         end
         default: begin
            pred_phase = PH_FAILED;
            t = make_token(KIND_ERROR, 8'h00, pred_fault);
         end
      endcase
      return t;
   endfunction

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_token();
      parse_token_type want;
      if (pending_tokens.size() == 0) begin
         flag_mismatch($sformatf("unexpected result kind=%0d byte=%02h code=%0d",
                                 rsp_kind, rsp_out_byte, rsp_error_code));
      end else begin
         want = pending_tokens.pop_front();
         if (rsp_kind !== want.kind || rsp_out_byte !== want.data ||
             rsp_error_code !== want.code)
            flag_mismatch($sformatf(
               "expected kind=%0d byte=%02h code=%0d, got kind=%0d byte=%02h code=%0d",
               want.kind, want.data, want.code, rsp_kind, rsp_out_byte, rsp_error_code));
      end
   endtask

   // Result side: check each transaction, then hold stall for a random gap unless in a burst.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         check_token();
         if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
         rsp_gap = rsp_burst ? 0 : $urandom_range(0, 17);
         rsp_hold_left <= rsp_gap;
         rsp_stall <= (rsp_gap != 0);
      end else if (rsp_hold_left > 1) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_hold_left <= 0;
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(logic [7:0] b, logic eoi = 1'b0);
      int gap;
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_tokens.insert(pending_tokens.size(), predict_parse(b, eoi));
      sent_count++;
      if ($urandom_range(0, 63) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i]);
   endtask

   function automatic logic [7:0] pick_byte_except(logic [7:0] a, logic [7:0] b,
                                                   logic [7:0] c);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == a || v == b || v == c);
      return v;
   endfunction

   function automatic logic [7:0] pick_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic send_name(int len);
      send_item(pick_byte_except(CH_RBRACE, CH_COLON, CH_LPAREN));
      for (int i = 1; i < len; i++) send_item(pick_byte_except(CH_COLON, CH_LPAREN, CH_COLON));
   endtask

   // Decimal size with optional leading zeros, then the closing parenthesis.
   task automatic send_size_field(int size);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) send_item(CH_ZERO);
      send_text($sformatf("%0d", size));
      send_item(CH_RPAREN);
   endtask

   task automatic send_binary_head(int size);
      send_name($urandom_range(1, 5));
      send_item(CH_LPAREN);
      send_size_field(size);
   endtask

   task automatic send_property();
      int size;
      if ($urandom_range(0, 1) == 0) begin
         send_name($urandom_range(1, 5));
         send_item(CH_COLON);
         repeat ($urandom_range(0, 8)) send_item(pick_byte_except(CH_SEMI, CH_SEMI, CH_SEMI));
         send_item(CH_SEMI);
      end else begin
         size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
         send_binary_head(size);
         send_item(CH_COLON);
         repeat (size) send_item(8'($urandom_range(0, 255)));
         send_item(CH_SEMI);
      end
   endtask

   task automatic test_open_brace();
      send_item(CH_LBRACE);
   endtask

   // Names and text made of boundary bytes and delimiters that are plain data there.
   task automatic test_text_extremes();
      send_item(8'h00);
      send_item(8'hFF);
      send_item(CH_RBRACE);
      send_item(CH_COLON);
      send_item(8'h00);
      send_item(8'hFF);
      send_item(CH_LBRACE);
      send_item(CH_RBRACE);
      send_item(CH_LPAREN);
      send_item(CH_RPAREN);
      send_item(CH_COLON);
      send_item(CH_SEMI);
   endtask

   // A zero size goes straight to the semicolon; leading zeros do not change the size.
   task automatic test_binary_sizes();
      send_text("a(0):;");
      send_text("b(002):");
      send_item(8'hFF);
      send_item(CH_SEMI);
      send_item(CH_SEMI);
   endtask

   task automatic test_random_dictionary();
      int target;
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) send_property();
   endtask

   // Only one way of ending the stream fits in a run, so the seed picks it.
   task automatic test_stream_ending();
      int size;
      int n;
      case ($urandom_range(0, 12))
         0: send_item(CH_RBRACE);
         1: send_item(8'($urandom_range(0, 255)), 1'b1);
         2: send_item($urandom_range(0, 1) ? CH_COLON : CH_LPAREN);
         3: begin
            send_name($urandom_range(1, 4));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         4: begin
            send_name($urandom_range(1, 4));
            send_item(CH_COLON);
            repeat ($urandom_range(0, 4)) send_item(pick_byte_except(CH_SEMI, CH_SEMI, CH_SEMI));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         5: begin
            send_name($urandom_range(1, 4));
            send_item(CH_LPAREN);
            repeat ($urandom_range(0, 3)) send_item(pick_digit());
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         6: begin
            send_name($urandom_range(1, 4));
            send_item(CH_LPAREN);
            n = $urandom_range(0, 3);
            repeat (n) send_item(pick_digit());
            // A closing parenthesis is only legal once a digit has been seen.
            do size = $urandom_range(0, 255);
            while ((size >= CH_ZERO && size <= CH_NINE) || (n != 0 && size == CH_RPAREN));
            send_item(8'(size));
         end
         7: begin
            send_binary_head($urandom_range(1, 30));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         8: begin
            send_binary_head($urandom_range(0, 30));
            send_item(pick_byte_except(CH_COLON, CH_COLON, CH_COLON));
         end
         9: begin
            size = $urandom_range(2, 20);
            send_binary_head(size);
            send_item(CH_COLON);
            repeat ($urandom_range(0, size - 1)) send_item(8'($urandom_range(0, 255)));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         10: begin
            // Far more digits than 64 bits can hold, so the size sticks at its ceiling.
            send_name($urandom_range(1, 4));
            send_item(CH_LPAREN);
            send_item(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat (21) send_item(pick_digit());
            send_item(CH_RPAREN);
            send_item(CH_COLON);
            repeat ($urandom_range(0, 10)) send_item(8'($urandom_range(0, 255)));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         11: begin
            size = $urandom_range(0, 10);
            send_binary_head(size);
            send_item(CH_COLON);
            repeat (size) send_item(8'($urandom_range(0, 255)));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         default: begin
            size = $urandom_range(0, 10);
            send_binary_head(size);
            send_item(CH_COLON);
            repeat (size) send_item(8'($urandom_range(0, 255)));
            send_item(pick_byte_except(CH_SEMI, CH_SEMI, CH_SEMI));
         end
      endcase
   endtask

   // Once closed the parser stays quiet; once failed it repeats the same error.
   task automatic test_after_end();
      repeat ($urandom_range(4, 10))
         send_item(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_open_brace();
      test_text_extremes();
      test_binary_sizes();
      test_random_dictionary();
      test_stream_ending();
      test_after_end();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_tokens.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
design/dpsp_pkg.sv
design/dpsp_in_reg.sv
design/dpsp_core.sv
design/dict_property_stream_parser_top.sv
sim/tb_top.sv
